### design/dnsr_pkg.sv
`default_nettype none
package dnsr_pkg;

  localparam int CUR_W = 18;
  localparam int HOP_W = 4;

  localparam logic [2:0] RC_HEADER   = 3'd0;
  localparam logic [2:0] RC_NAME     = 3'd1;
  localparam logic [2:0] RC_QUESTION = 3'd2;
  localparam logic [2:0] RC_RECORD   = 3'd3;
  localparam logic [2:0] RC_IPV4     = 3'd4;
  localparam logic [2:0] RC_REC_END  = 3'd5;
  localparam logic [2:0] RC_FINISHED = 3'd6;
  localparam logic [2:0] RC_ERROR    = 3'd7;

  localparam logic [15:0] ERR_SHORT    = 16'd0;
  localparam logic [15:0] ERR_TXID     = 16'd1;
  localparam logic [15:0] ERR_RCODE    = 16'd2;
  localparam logic [15:0] ERR_FIXED    = 16'd3;
  localparam logic [15:0] ERR_NAME     = 16'd4;
  localparam logic [15:0] ERR_PTR_CUT  = 16'd5;
  localparam logic [15:0] ERR_HOPS     = 16'd6;
  localparam logic [15:0] ERR_PTR_PAST = 16'd7;
  localparam logic [15:0] ERR_PTR_HDR  = 16'd8;
  localparam logic [15:0] ERR_RDATA    = 16'd9;
  localparam logic [15:0] ERR_A_LEN    = 16'd10;
  localparam logic [15:0] ERR_COUNT    = 16'd11;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_NS    = 16'd2;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_PTR   = 16'd12;

  localparam logic [1:0] SEC_QUESTION   = 2'd0;
  localparam logic [1:0] SEC_ANSWER     = 2'd1;
  localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

  localparam logic [CUR_W-1:0] HDR_LEN = CUR_W'(12);
  localparam logic [7:0]       DOT     = 8'h2E;
  localparam logic [1:0]       PTR_TAG = 2'b11;
  localparam logic [3:0]       RCODE_MASK = 4'hF;

  typedef enum logic [2:0] {
    PH_LOAD, PH_HEAD, PH_NEXT, PH_QNAME, PH_RNAME, PH_RDNAME, PH_REND, PH_STOP
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_ISSUE, S_RD_CAP, S_HDR0, S_HDR1, S_HDR2, S_NEXT, S_SECCNT,
    S_WALK, S_WALK_CH, S_WALK_B, S_WALK_PTR, S_NAME_END, S_REC0, S_REC1,
    S_REC2, S_QINFO, S_IPV4, S_REND
  } state_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [1:0]  section;
    logic        in_rdata;
    logic [7:0]  name_char;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [31:0] time_to_live;
    logic [31:0] ipv4_address;
  } result_t;

  function automatic result_t make_err(input logic [1:0] sec, input logic [15:0] num,
                                       input logic [15:0] b, input logic [15:0] cnt);
    result_t r;
    r = '0;
    r.code = RC_ERROR;
    r.section = sec;
    r.word_a = num;
    r.word_b = b;
    if (num == ERR_COUNT) r.additional_count = cnt;
    return r;
  endfunction

  function automatic result_t make_char(input logic [1:0] sec, input logic rdata,
                                        input logic [7:0] ch);
    result_t r;
    r = '0;
    r.code = RC_NAME;
    r.section = sec;
    r.in_rdata = rdata;
    r.name_char = ch;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/dns_response_parser.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | start / busy       | in_kind, in_data_byte, in_last_byte
// result    | out_valid strobe   | out_code .. out_ipv4_address
// config    | cfg_we             | cfg_wdata (expected transaction id)
//
// a load appends one packet byte to the packet store while it has room; a
// fetch reads packet bytes one at a time through the single read port of
// the packet store, and takes longer when records are skipped or pointers
// are followed. reset clears control state only; the packet store is not
// cleared. busy rises when the two-entry command queue is full; results are
// strobed for one cycle and cannot be held off.
`default_nettype none
module dns_response_parser
  import dnsr_pkg::*;
#(
  parameter int BUFFER_BYTES     = 512,
  parameter int MAX_POINTER_HOPS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  output logic [2:0]       out_code,
  output logic [1:0]       out_section,
  output logic             out_in_rdata,
  output logic [7:0]       out_name_char,
  output logic [15:0]      out_word_a,
  output logic [15:0]      out_word_b,
  output logic [15:0]      out_word_c,
  output logic [15:0]      out_answer_count,
  output logic [15:0]      out_authority_count,
  output logic [15:0]      out_additional_count,
  output logic [31:0]      out_time_to_live,
  output logic [31:0]      out_ipv4_address
);

  logic    q_valid, q_pop;
  cmd_t    q_cmd;
  result_t res;

  dnsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_kind),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  dnsr_engine #(
    .BUFFER_BYTES     (BUFFER_BYTES),
    .MAX_POINTER_HOPS (MAX_POINTER_HOPS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_code             = res.code;
  assign out_section          = res.section;
  assign out_in_rdata         = res.in_rdata;
  assign out_name_char        = res.name_char;
  assign out_word_a           = res.word_a;
  assign out_word_b           = res.word_b;
  assign out_word_c           = res.word_c;
  assign out_answer_count     = res.answer_count;
  assign out_authority_count  = res.authority_count;
  assign out_additional_count = res.additional_count;
  assign out_time_to_live     = res.time_to_live;
  assign out_ipv4_address     = res.ipv4_address;

endmodule
`default_nettype wire

### design/dnsr_ram.sv
`default_nettype none
module dnsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### design/dnsr_front.sv
`default_nettype none
module dnsr_front
  import dnsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic kind,
  input  wire logic [7:0] data_byte,
  input  wire logic last_byte,
  output logic      busy,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic q_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // classify the transaction on entry
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].load <= !kind;
      q_r[wp_r].data <= data_byte;
      q_r[wp_r].last <= last_byte;
    end
  end

endmodule
`default_nettype wire

### design/dnsr_engine.sv
`default_nettype none
module dnsr_engine
  import dnsr_pkg::*;
#(
  parameter int BUFFER_BYTES     = 512,
  parameter int MAX_POINTER_HOPS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_pop,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             res_valid,
  output result_t          res
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  phase_t             phase_r, phase_nxt;
  logic [LW-1:0]      len_r, len_nxt, wlen;
  logic [CUR_W-1:0]   cur_r, cur_nxt, resume_r, resume_nxt;
  logic [CUR_W-1:0]   rec_start_r, rec_start_nxt, rec_end_r, rec_end_nxt;
  logic [CUR_W-1:0]   rd_ptr_r, rd_ptr_nxt, len_x, rend, sec_addr;
  logic [HOP_W-1:0]   hop_r, hop_nxt;
  logic [7:0]         label_r, label_nxt, byte_in;
  logic               started_r, started_nxt;
  logic [1:0]         sec_r, sec_nxt, sec_inc;
  logic [15:0]        items_r, items_nxt, rtype_r, rtype_nxt, class_r, class_nxt;
  logic [15:0]        hid_r, hid_nxt, hflags_r, hflags_nxt, qd_r, qd_nxt, an_r, an_nxt;
  logic [15:0]        txid_r;
  logic [17:0]        declared_r, declared_nxt, parsed_r, parsed_nxt;
  logic [31:0]        ttl_r, ttl_nxt, acc_r, acc_nxt;
  logic [2:0]         rd_cnt_r, rd_cnt_nxt;
  logic               oob_r, oob_nxt;
  logic               valid_r, valid_nxt;
  result_t            res_r, res_nxt;
  logic               ram_we;
  logic [7:0]         ram_rdata;

  logic fetch, len_short, id_bad, rc_bad, items_zero, sec_last, cnt_short;
  logic label_nz, cur_past, b_zero, b_ptr, ptr_cut, lab_over;
  logic hop_over, off_past, off_hdr, end_over, q_over, is_a, rd_over, type_ok, a_bad;
  logic skip;

  assign wlen    = (phase_r != PH_LOAD) ? '0 : len_r;
  assign ram_we  = (state_r == S_IDLE) && q_valid && q_cmd.load &&
                   (wlen < LW'(BUFFER_BYTES));

  dnsr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wlen[AW-1:0]),
    .wdata (q_cmd.data),
    .raddr (rd_ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign len_x      = CUR_W'(len_r);
  assign byte_in    = oob_r ? 8'h00 : ram_rdata;
  assign fetch      = q_valid && !q_cmd.load;
  assign len_short  = len_x < HDR_LEN;
  assign id_bad     = acc_r[31:16] != txid_r;
  assign rc_bad     = acc_r[3:0] != 4'd0;
  assign items_zero = items_r == 16'd0;
  assign sec_last   = sec_r == SEC_ADDITIONAL;
  assign sec_inc    = sec_r + 2'd1;
  assign sec_addr   = CUR_W'({sec_inc, 1'b0}) + CUR_W'(4);
  assign cnt_short  = parsed_r < declared_r;
  assign label_nz   = label_r != 8'd0;
  assign cur_past   = cur_r >= len_x;
  assign b_zero     = acc_r[7:0] == 8'd0;
  assign b_ptr      = acc_r[7:6] == PTR_TAG;
  assign ptr_cut    = (cur_r + CUR_W'(1)) >= len_x;
  assign lab_over   = (cur_r + CUR_W'(acc_r[7:0]) + CUR_W'(1)) > len_x;
  assign hop_over   = hop_r >= HOP_W'(MAX_POINTER_HOPS);
  assign off_past   = CUR_W'(acc_r[13:0]) >= len_x;
  assign off_hdr    = CUR_W'(acc_r[13:0]) < HDR_LEN;
  assign end_over   = (cur_r + CUR_W'(10)) > len_x;
  assign q_over     = (cur_r + CUR_W'(4)) > len_x;
  assign is_a       = rtype_r == TYPE_A;
  assign rend       = cur_r + CUR_W'(10) + CUR_W'(acc_r[15:0]);
  assign rd_over    = rend > len_x;
  assign type_ok    = (rtype_r == TYPE_A) || (rtype_r == TYPE_NS) ||
                      (rtype_r == TYPE_CNAME) || (rtype_r == TYPE_PTR);
  assign a_bad      = is_a && (acc_r[15:0] != 16'd4);
  assign skip       = phase_r == PH_NEXT;

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: begin
        if (fetch) begin
          case (phase_r)
            PH_HEAD: begin
              state_nxt = len_short ? S_IDLE : S_RD_ISSUE;
              ret_nxt   = S_HDR0;
            end
            PH_NEXT:   state_nxt = S_NEXT;
            PH_QNAME,
            PH_RNAME,
            PH_RDNAME: state_nxt = S_WALK;
            PH_REND:   state_nxt = S_REND;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_CAP;
      S_RD_CAP:   state_nxt = (rd_cnt_r == 3'd1) ? ret_r : S_RD_ISSUE;
      S_HDR0: begin
        if (id_bad || rc_bad) state_nxt = S_IDLE;
        else begin
          state_nxt = S_RD_ISSUE;
          ret_nxt   = S_HDR1;
        end
      end
      S_HDR1: begin
        state_nxt = S_RD_ISSUE;
        ret_nxt   = S_HDR2;
      end
      S_HDR2: state_nxt = S_IDLE;
      S_NEXT: begin
        if (items_zero) begin
          if (sec_last) state_nxt = S_IDLE;
          else begin
            state_nxt = S_RD_ISSUE;
            ret_nxt   = S_SECCNT;
          end
        end else state_nxt = S_WALK;
      end
      S_SECCNT: state_nxt = S_NEXT;
      S_WALK: begin
        if (label_nz) begin
          state_nxt = S_RD_ISSUE;
          ret_nxt   = S_WALK_CH;
        end else if (cur_past) state_nxt = S_IDLE;
        else begin
          state_nxt = S_RD_ISSUE;
          ret_nxt   = S_WALK_B;
        end
      end
      S_WALK_CH: state_nxt = skip ? S_WALK : S_IDLE;
      S_WALK_B: begin
        if (b_zero) state_nxt = S_NAME_END;
        else if (b_ptr) begin
          if (ptr_cut) state_nxt = S_IDLE;
          else begin
            state_nxt = S_RD_ISSUE;
            ret_nxt   = S_WALK_PTR;
          end
        end else if (lab_over) state_nxt = S_IDLE;
        else if (started_r && !skip) state_nxt = S_IDLE;
        else state_nxt = S_WALK;
      end
      S_WALK_PTR: state_nxt = (hop_over || off_past || off_hdr) ? S_IDLE : S_WALK;
      S_NAME_END: begin
        case (phase_r)
          PH_NEXT: begin
            state_nxt = end_over ? S_IDLE : S_RD_ISSUE;
            ret_nxt   = S_REC0;
          end
          PH_QNAME: begin
            state_nxt = q_over ? S_IDLE : S_RD_ISSUE;
            ret_nxt   = S_QINFO;
          end
          PH_RNAME: begin
            state_nxt = is_a ? S_RD_ISSUE : S_WALK;
            ret_nxt   = S_IPV4;
          end
          PH_RDNAME: state_nxt = S_REND;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_REC0: begin
        state_nxt = S_RD_ISSUE;
        ret_nxt   = S_REC1;
      end
      S_REC1: begin
        state_nxt = S_RD_ISSUE;
        ret_nxt   = S_REC2;
      end
      S_REC2: begin
        if (rd_over) state_nxt = S_IDLE;
        else if (!type_ok) state_nxt = S_NEXT;
        else if (a_bad) state_nxt = (sec_r != SEC_ANSWER) ? S_IDLE : S_NEXT;
        else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    resume_nxt    = resume_r;
    rec_start_nxt = rec_start_r;
    rec_end_nxt   = rec_end_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_cnt_nxt    = rd_cnt_r;
    hop_nxt       = hop_r;
    label_nxt     = label_r;
    started_nxt   = started_r;
    sec_nxt       = sec_r;
    items_nxt     = items_r;
    rtype_nxt     = rtype_r;
    class_nxt     = class_r;
    ttl_nxt       = ttl_r;
    hid_nxt       = hid_r;
    hflags_nxt    = hflags_r;
    qd_nxt        = qd_r;
    an_nxt        = an_r;
    declared_nxt  = declared_r;
    parsed_nxt    = parsed_r;
    acc_nxt       = acc_r;
    oob_nxt       = oob_r;
    q_pop         = 1'b0;
    valid_nxt     = 1'b0;
    res_nxt       = '0;
    case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.load) begin
          len_nxt   = wlen + LW'(wlen < LW'(BUFFER_BYTES));
          phase_nxt = q_cmd.last ? PH_HEAD : PH_LOAD;
        end else if (q_valid && phase_r == PH_HEAD) begin
          sec_nxt = SEC_QUESTION;
          if (len_short) begin
            valid_nxt = 1'b1;
            res_nxt   = make_err(SEC_QUESTION, ERR_SHORT, 16'd0, 16'd0);
            phase_nxt = PH_STOP;
          end else begin
            rd_ptr_nxt = '0;
            rd_cnt_nxt = 3'd4;
          end
        end
      end
      S_RD_ISSUE: oob_nxt = rd_ptr_r >= len_x;
      S_RD_CAP: begin
        acc_nxt    = {acc_r[23:0], byte_in};
        rd_ptr_nxt = rd_ptr_r + CUR_W'(1);
        rd_cnt_nxt = rd_cnt_r - 3'd1;
      end
      S_HDR0: begin
        if (id_bad) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_TXID, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else if (rc_bad) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_RCODE, {12'd0, acc_r[3:0] & RCODE_MASK}, 16'd0);
          phase_nxt = PH_STOP;
        end else begin
          hid_nxt    = acc_r[31:16];
          hflags_nxt = acc_r[15:0];
          rd_ptr_nxt = CUR_W'(4);
          rd_cnt_nxt = 3'd4;
        end
      end
      S_HDR1: begin
        qd_nxt     = acc_r[31:16];
        an_nxt     = acc_r[15:0];
        rd_ptr_nxt = CUR_W'(8);
        rd_cnt_nxt = 3'd4;
      end
      S_HDR2: begin
        valid_nxt                = 1'b1;
        res_nxt.code             = RC_HEADER;
        res_nxt.word_a           = hid_r;
        res_nxt.word_b           = hflags_r;
        res_nxt.word_c           = qd_r;
        res_nxt.answer_count     = an_r;
        res_nxt.authority_count  = acc_r[31:16];
        res_nxt.additional_count = acc_r[15:0];
        declared_nxt = 18'(an_r) + 18'(acc_r[31:16]) + 18'(acc_r[15:0]);
        parsed_nxt   = '0;
        cur_nxt      = HDR_LEN;
        items_nxt    = qd_r;
        phase_nxt    = PH_NEXT;
      end
      S_NEXT: begin
        if (items_zero) begin
          if (sec_last) begin
            valid_nxt = 1'b1;
            phase_nxt = PH_STOP;
            if (cnt_short) res_nxt = make_err(sec_r, ERR_COUNT, 16'd0, parsed_r[15:0]);
            else begin
              res_nxt.code             = RC_FINISHED;
              res_nxt.section          = SEC_ADDITIONAL;
              res_nxt.additional_count = parsed_r[15:0];
            end
          end else begin
            sec_nxt    = sec_inc;
            rd_ptr_nxt = sec_addr;
            rd_cnt_nxt = 3'd2;
          end
        end else begin
          items_nxt     = items_r - 16'd1;
          hop_nxt       = '0;
          label_nxt     = 8'd0;
          started_nxt   = 1'b0;
          rec_start_nxt = cur_r;
          if (sec_r == SEC_QUESTION) phase_nxt = PH_QNAME;
        end
      end
      S_SECCNT: items_nxt = acc_r[15:0];
      S_WALK: begin
        if (label_nz) begin
          rd_ptr_nxt = cur_r;
          rd_cnt_nxt = 3'd1;
          cur_nxt    = cur_r + CUR_W'(1);
          label_nxt  = label_r - 8'd1;
        end else if (cur_past) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_NAME, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else begin
          rd_ptr_nxt = cur_r;
          rd_cnt_nxt = 3'd1;
        end
      end
      S_WALK_CH: begin
        if (!skip) begin
          valid_nxt = 1'b1;
          res_nxt   = make_char(sec_r, phase_r == PH_RDNAME, acc_r[7:0]);
        end
      end
      S_WALK_B: begin
        if (b_zero) cur_nxt = (hop_r != '0) ? resume_r : cur_r + CUR_W'(1);
        else if (b_ptr) begin
          if (ptr_cut) begin
            valid_nxt = 1'b1;
            res_nxt   = make_err(sec_r, ERR_PTR_CUT, 16'd0, 16'd0);
            phase_nxt = PH_STOP;
          end else begin
            rd_ptr_nxt = cur_r + CUR_W'(1);
            rd_cnt_nxt = 3'd1;
          end
        end else if (lab_over) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_NAME, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else begin
          cur_nxt     = cur_r + CUR_W'(1);
          label_nxt   = acc_r[7:0];
          started_nxt = 1'b1;
          if (started_r && !skip) begin
            valid_nxt = 1'b1;
            res_nxt   = make_char(sec_r, phase_r == PH_RDNAME, DOT);
          end
        end
      end
      S_WALK_PTR: begin
        if (hop_r == '0) resume_nxt = cur_r + CUR_W'(2);
        hop_nxt = hop_r + HOP_W'(1);
        if (hop_over) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_HOPS, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else if (off_past) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_PTR_PAST, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else if (off_hdr) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_PTR_HDR, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else cur_nxt = CUR_W'(acc_r[13:0]);
      end
      S_NAME_END: begin
        case (phase_r)
          PH_NEXT: begin
            if (end_over) begin
              valid_nxt = 1'b1;
              res_nxt   = make_err(sec_r, ERR_FIXED, 16'd0, 16'd0);
              phase_nxt = PH_STOP;
            end else begin
              rd_ptr_nxt = cur_r;
              rd_cnt_nxt = 3'd4;
            end
          end
          PH_QNAME: begin
            if (q_over) begin
              valid_nxt = 1'b1;
              res_nxt   = make_err(sec_r, ERR_FIXED, 16'd0, 16'd0);
              phase_nxt = PH_STOP;
            end else begin
              rd_ptr_nxt = cur_r;
              rd_cnt_nxt = 3'd4;
            end
          end
          PH_RNAME: begin
            cur_nxt = cur_r + CUR_W'(10);
            if (is_a) begin
              rd_ptr_nxt = cur_r + CUR_W'(10);
              rd_cnt_nxt = 3'd4;
            end else begin
              hop_nxt     = '0;
              label_nxt   = 8'd0;
              started_nxt = 1'b0;
              phase_nxt   = PH_RDNAME;
            end
          end
          PH_RDNAME: phase_nxt = PH_REND;
          default: ;
        endcase
      end
      S_REC0: begin
        rtype_nxt  = acc_r[31:16];
        class_nxt  = acc_r[15:0];
        rd_ptr_nxt = cur_r + CUR_W'(4);
        rd_cnt_nxt = 3'd4;
      end
      S_REC1: begin
        ttl_nxt    = acc_r;
        rd_ptr_nxt = cur_r + CUR_W'(8);
        rd_cnt_nxt = 3'd2;
      end
      S_REC2: begin
        if (rd_over) begin
          valid_nxt = 1'b1;
          res_nxt   = make_err(sec_r, ERR_RDATA, 16'd0, 16'd0);
          phase_nxt = PH_STOP;
        end else if (!type_ok) cur_nxt = rend;
        else if (a_bad) begin
          if (sec_r != SEC_ANSWER) begin
            valid_nxt = 1'b1;
            res_nxt   = make_err(sec_r, ERR_A_LEN, 16'd0, 16'd0);
            phase_nxt = PH_STOP;
          end else cur_nxt = rend;
        end else begin
          valid_nxt            = 1'b1;
          res_nxt.code         = RC_RECORD;
          res_nxt.section      = sec_r;
          res_nxt.word_a       = rtype_r;
          res_nxt.word_b       = class_r;
          res_nxt.word_c       = acc_r[15:0];
          res_nxt.time_to_live = ttl_r;
          rec_end_nxt = rend;
          cur_nxt     = rec_start_r;
          hop_nxt     = '0;
          label_nxt   = 8'd0;
          started_nxt = 1'b0;
          phase_nxt   = PH_RNAME;
        end
      end
      S_QINFO: begin
        valid_nxt      = 1'b1;
        res_nxt.code   = RC_QUESTION;
        res_nxt.word_a = acc_r[31:16];
        res_nxt.word_b = acc_r[15:0];
        cur_nxt        = cur_r + CUR_W'(4);
        phase_nxt      = PH_NEXT;
      end
      S_IPV4: begin
        valid_nxt            = 1'b1;
        res_nxt.code         = RC_IPV4;
        res_nxt.section      = sec_r;
        res_nxt.ipv4_address = acc_r;
        phase_nxt            = PH_REND;
      end
      S_REND: begin
        valid_nxt       = 1'b1;
        res_nxt.code    = RC_REC_END;
        res_nxt.section = sec_r;
        res_nxt.word_a  = rtype_r;
        parsed_nxt      = parsed_r + 18'd1;
        cur_nxt         = rec_end_r;
        phase_nxt       = PH_NEXT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      phase_r    <= PH_LOAD;
      len_r      <= '0;
      cur_r      <= '0;
      resume_r   <= '0;
      hop_r      <= '0;
      label_r    <= 8'd0;
      started_r  <= 1'b0;
      sec_r      <= 2'd0;
      items_r    <= 16'd0;
      declared_r <= '0;
      parsed_r   <= '0;
      rtype_r    <= 16'd0;
      rd_cnt_r   <= 3'd0;
      txid_r     <= 16'd0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      cur_r      <= cur_nxt;
      resume_r   <= resume_nxt;
      hop_r      <= hop_nxt;
      label_r    <= label_nxt;
      started_r  <= started_nxt;
      sec_r      <= sec_nxt;
      items_r    <= items_nxt;
      declared_r <= declared_nxt;
      parsed_r   <= parsed_nxt;
      rtype_r    <= rtype_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      if (cfg_we) txid_r <= cfg_wdata;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_start_r <= rec_start_nxt;
    rec_end_r   <= rec_end_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    class_r     <= class_nxt;
    ttl_r       <= ttl_nxt;
    hid_r       <= hid_nxt;
    hflags_r    <= hflags_nxt;
    qd_r        <= qd_nxt;
    an_r        <= an_nxt;
    acc_r       <= acc_nxt;
    oob_r       <= oob_nxt;
    res_r       <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
